// File: hw/rtl/pss_pkg.sv
// Package for the positional sequence store.
// Holds the field widths, the opcode and status codes, and the control word
// that the controller hands to the row of cells. It depends on nothing.
package pss_pkg;

    localparam int PSS_CAPACITY = 64;
    localparam int PSS_DATA_W   = 32;
    localparam int PSS_OP_W     = 4;
    localparam int PSS_POS_W    = 8;

    typedef enum logic [PSS_OP_W-1:0] {
        OP_ADD_HEAD = 4'd0,
        OP_DEL_HEAD = 4'd1,
        OP_MOD_HEAD = 4'd2,
        OP_ADD_TAIL = 4'd3,
        OP_DEL_TAIL = 4'd4,
        OP_MOD_TAIL = 4'd5,
        OP_ADD_AT   = 4'd6,
        OP_DEL_AT   = 4'd7,
        OP_MOD_AT   = 4'd8,
        OP_READ_AT  = 4'd9
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_REJECTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic ins;
        logic del;
        logic wr;
        logic rd;
    } t_cell_ctl;

endpackage

// File: hw/rtl/pss_cell.sv
// One cell of the element row: holds one list element and one stage of the
// read bus that walks toward cell 0. Depends on pss_pkg.
module pss_cell
    import pss_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic [PSS_DATA_W-1:0] i_value,
    input  logic [PSS_DATA_W-1:0] i_left,
    input  logic [PSS_DATA_W-1:0] i_right,
    input  logic [PSS_DATA_W-1:0] i_bus,
    output logic [PSS_DATA_W-1:0] o_data,
    output logic [PSS_DATA_W-1:0] o_bus
);

    localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(INDEX);

    logic [PSS_DATA_W-1:0] r_data;
    logic [PSS_DATA_W-1:0] r_bus;
    logic                  match;
    logic                  above;

    assign match = (CELL_IDX == i_pos);
    assign above = (CELL_IDX > i_pos);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && above) begin
            r_data <= i_left;
        end else if ((i_ctl.ins || i_ctl.wr) && match) begin
            r_data <= i_value;
        end else if (i_ctl.del && (above || match)) begin
            r_data <= i_right;
        end
        r_bus <= (i_ctl.rd && match) ? r_data : i_bus;
    end

    assign o_data = r_data;
    assign o_bus  = r_bus;

endmodule

// File: hw/rtl/pss_ctrl.sv
// Controller of the positional sequence store: decodes each item against the
// element count, drives the cell row and holds the result register.
// Depends on pss_pkg.
module pss_ctrl
    import pss_pkg::*;
#(
    parameter int CAPACITY = PSS_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [PSS_OP_W-1:0]          i_opcode,
    input  logic [PSS_POS_W-1:0]         i_position,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [CNT_W-1:0]             o_count,
    output logic signed [PSS_DATA_W-1:0] o_read_value,
    output t_cell_ctl                    o_ctl,
    output logic [IDX_W-1:0]             o_pos,
    input  logic [PSS_DATA_W-1:0]        i_bus
);

    localparam int CMP_W = (CNT_W > PSS_POS_W) ? CNT_W : PSS_POS_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_left;
    logic                    r_ovalid;
    t_status                 r_status;
    logic [CNT_W-1:0]        r_ocount;
    logic [PSS_DATA_W-1:0]   r_rdval;

    logic                    accept;
    logic                    out_free;
    logic                    load_out;
    logic                    empty;
    logic                    full;
    logic                    pos_in;
    logic [IDX_W-1:0]        pos_idx;
    logic [IDX_W-1:0]        cnt_idx;
    logic [IDX_W-1:0]        last_idx;
    t_cell_ctl               dec_ctl;
    logic [IDX_W-1:0]        dec_pos;
    t_status                 dec_status;
    logic [CNT_W-1:0]        dec_count;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state == S_READ) || (r_ovalid && i_stall);
    assign accept   = i_valid && !o_stall;
    assign load_out = ((r_state == S_IDLE) && accept && !dec_ctl.rd)
                   || ((r_state == S_READ) && (r_left == '0) && out_free);

    assign empty    = (r_count == '0);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign pos_in   = (CMP_W'(i_position) < CMP_W'(r_count));
    assign pos_idx  = IDX_W'(i_position);
    assign cnt_idx  = IDX_W'(r_count);
    assign last_idx = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        dec_ctl    = '0;
        dec_pos    = '0;
        dec_status = ST_IGNORED;
        dec_count  = r_count;
        unique case (i_opcode)
            OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_AT: begin
                if ((i_opcode == OP_ADD_AT) && empty && (i_position != '0)) begin
                    dec_status = ST_REJECTED;
                end else if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    dec_ctl.ins = 1'b1;
                    dec_status  = ST_DONE;
                    dec_count   = r_count + CNT_W'(1);
                    if (i_opcode == OP_ADD_HEAD) begin
                        dec_pos = '0;
                    end else if ((i_opcode == OP_ADD_AT) && pos_in) begin
                        dec_pos = pos_idx;
                    end else begin
                        dec_pos = cnt_idx;
                    end
                end
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
                if (!empty) begin
                    dec_ctl.del = 1'b1;
                    dec_status  = ST_DONE;
                    dec_count   = r_count - CNT_W'(1);
                    dec_pos     = (i_opcode == OP_DEL_HEAD) ? '0 : last_idx;
                end
            end
            OP_DEL_AT: begin
                if (pos_in) begin
                    dec_ctl.del = 1'b1;
                    dec_status  = ST_DONE;
                    dec_count   = r_count - CNT_W'(1);
                    dec_pos     = pos_idx;
                end
            end
            OP_MOD_HEAD, OP_MOD_TAIL: begin
                if (!empty) begin
                    dec_ctl.wr = 1'b1;
                    dec_status = ST_DONE;
                    dec_pos    = (i_opcode == OP_MOD_HEAD) ? '0 : last_idx;
                end
            end
            OP_MOD_AT: begin
                if (empty) begin
                    dec_status = ST_REJECTED;
                end else begin
                    dec_ctl.wr = 1'b1;
                    dec_status = ST_DONE;
                    dec_pos    = pos_in ? pos_idx : last_idx;
                end
            end
            OP_READ_AT: begin
                if (pos_in) begin
                    dec_ctl.rd = 1'b1;
                    dec_status = ST_DONE;
                    dec_pos    = pos_idx;
                end
            end
            default: begin
                dec_status = ST_IGNORED;
            end
        endcase
    end

    assign o_ctl = accept ? dec_ctl : '0;
    assign o_pos = dec_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_count <= dec_count;
                        if (dec_ctl.rd) begin
                            r_state <= S_READ;
                            r_left  <= dec_pos;
                        end else begin
                            r_status <= dec_status;
                            r_ocount <= dec_count;
                            r_rdval  <= '0;
                        end
                    end
                end
                S_READ: begin
                    if (r_left != '0) begin
                        r_left <= r_left - IDX_W'(1);
                    end else if (out_free) begin
                        r_status <= ST_DONE;
                        r_ocount <= r_count;
                        r_rdval  <= i_bus;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_count      = r_ocount;
    assign o_read_value = r_rdval;

endmodule

// File: hw/rtl/positional_sequence_store.sv
// Positional sequence store: an ordered list of signed 32-bit values kept in a
// row of cells. Depends on pss_pkg, pss_ctrl and pss_cell.
//
// The input channel carries an opcode, a position and a value under i_valid
// and o_stall; an item is taken at a clock edge with i_valid high and o_stall
// low. Every item gives exactly one result on the output channel under
// o_valid and i_stall: a status, the element count after the operation and
// the value read.
//
// For insert, delete and modify items every cell compares its own index with
// the position and takes its left neighbor, its right neighbor or the new
// value in the same edge. The output register takes the result at the edge
// that takes the item, and the next item may follow at once. A read loads the
// selected element onto the read bus, which moves it one cell per cycle toward
// cell 0; o_stall stays high while the controller waits in its read state, and
// the result is loaded once the element reaches cell 0. A read that finds
// nothing returns at once.
//
// The output register holds a result while i_stall is high; one more item is
// taken only once that result is leaving. Synchronous reset empties the list
// and drops any pending result; cell contents are left as they were.
module positional_sequence_store
    import pss_pkg::*;
#(
    parameter int CAPACITY = PSS_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [PSS_OP_W-1:0]          i_opcode,
    input  logic [PSS_POS_W-1:0]         i_position,
    input  logic signed [PSS_DATA_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [CNT_W-1:0]             o_count,
    output logic signed [PSS_DATA_W-1:0] o_read_value
);

    localparam int IDX_W = $clog2(CAPACITY);

    t_cell_ctl             cell_ctl;
    logic [IDX_W-1:0]      cell_pos;
    logic [PSS_DATA_W-1:0] value_bits;
    logic [PSS_DATA_W-1:0] cell_data [CAPACITY];
    logic [PSS_DATA_W-1:0] bus_q     [CAPACITY+1];

    assign value_bits      = i_value;
    assign bus_q[CAPACITY] = '0;

    pss_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_read_value (o_read_value),
        .o_ctl        (cell_ctl),
        .o_pos        (cell_pos),
        .i_bus        (bus_q[0])
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [PSS_DATA_W-1:0] left_in;
        logic [PSS_DATA_W-1:0] right_in;

        if (g == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_inner_l
            assign left_in = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_in = cell_data[g];
        end else begin : g_inner_r
            assign right_in = cell_data[g+1];
        end

        pss_cell #(
            .IDX_W (IDX_W),
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_pos   (cell_pos),
            .i_value (value_bits),
            .i_left  (left_in),
            .i_right (right_in),
            .i_bus   (bus_q[g+1]),
            .o_data  (cell_data[g]),
            .o_bus   (bus_q[g])
        );
    end

endmodule

// File: hw/rtl/pss_checker.sv
// Port-level checker for the positional sequence store, bound to the top
// level. Depends on pss_pkg and positional_sequence_store.
module pss_checker
    import pss_pkg::*;
#(
    parameter int CAPACITY = PSS_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [1:0]                   o_status,
    input logic [CNT_W-1:0]             o_count,
    input logic signed [PSS_DATA_W-1:0] o_read_value
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CNT_W'(CAPACITY)))
        else $error("element count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_count == CNT_W'(CAPACITY)))
        else $error("full status with list not full");

    a_reject_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_REJECTED)) |-> (o_count == '0))
        else $error("rejected status with list not empty");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
        (o_valid && $stable(o_status) && $stable(o_count) && $stable(o_read_value)))
        else $error("stalled result changed");

endmodule

bind positional_sequence_store pss_checker #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
) u_pss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_count      (o_count),
    .o_read_value (o_read_value)
);
